/* rtl/wstq_pkg.sv */
// ----------------------------------------------------------------------------
// wstq_pkg
// Shared constants, codes and types for the work-stealing task queues.
// ----------------------------------------------------------------------------
package wstq_pkg;

    // sizing
    localparam int MAX_WORKERS = 16;
    localparam int QUEUE_DEPTH = 64;
    localparam int TASK_WIDTH  = 32;

    // fixed field widths of the interface
    localparam int HANDLE_W = 32;   // task_handle / task_out
    localparam int AW_W     = 5;    // active_workers register
    localparam int QL_W     = 7;    // queue_limit register
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    // derived widths
    localparam int WID_W       = $clog2(MAX_WORKERS);
    localparam int NW_W        = $clog2(MAX_WORKERS + 1);
    localparam int SLOT_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int PTR_W       = SLOT_W + CNT_W;
    localparam int STORE_DEPTH = MAX_WORKERS * QUEUE_DEPTH;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int TOTAL_W     = $clog2(STORE_DEPTH + 1);

    // operation codes
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // register indexes
    localparam int REG_IDX_W = 1;
    typedef logic [REG_IDX_W-1:0] reg_idx_t;
    localparam reg_idx_t REG_ACTIVE_WORKERS = 1'b0;
    localparam reg_idx_t REG_QUEUE_LIMIT    = 1'b1;

    // steal scan result
    typedef struct packed {
        logic             found;
        logic [WID_W-1:0] queue;
    } scan_res_t;

endpackage

/* rtl/work_stealing_task_queues.sv */
// ----------------------------------------------------------------------------
// work_stealing_task_queues
// Per-worker bounded FIFO task queues with round-robin stealing on pop.
// ----------------------------------------------------------------------------
//
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------------
//  in       | in_valid/in_ready  | kind, worker_id, task_handle
//  out      | out_valid/out_ready| done_res, task_out, stolen, source_queue,
//           |                    |   waiting_total
//  cfg      | APB psel/penable   | paddr 0: active_workers, 4: queue_limit
//
//  A push goes through accept and pointer read, then pointer
//  read-modify-write; a pop then adds the task store read. Both
//  memories register their read data.
//  Reset clears pointers through per-queue valid bits; no clearing pass.
//  One word is in flight at a time; a waiting output word does not block
//  the next accept, but a new result stalls until the output slot frees.
//
module work_stealing_task_queues
    import wstq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // request channel
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                kind,
    input  logic [WID_W-1:0]    worker_id,
    input  logic [HANDLE_W-1:0] task_handle,
    // result channel
    output logic                out_valid,
    input  logic                out_ready,
    output logic                done_res,
    output logic [HANDLE_W-1:0] task_out,
    output logic                stolen,
    output logic [WID_W-1:0]    source_queue,
    output logic [TOTAL_W-1:0]  waiting_total,
    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,   // waiting for a request word
        S_RMW  = 4'b0010,   // pointer data back, update queue
        S_LOAD = 4'b0100,   // task store data back (pop)
        S_EMIT = 4'b1000    // result parked until the output frees
    } state_t;

    state_t state_reg, state_next;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [AW_W-1:0] aw_reg;
    logic [QL_W-1:0] ql_reg;
    reg_idx_t        cfg_idx;
    logic            cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[PADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            aw_reg <= AW_W'(16);
            ql_reg <= QL_W'(64);
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_ACTIVE_WORKERS: aw_reg <= pwdata[AW_W-1:0];
                REG_QUEUE_LIMIT:    ql_reg <= pwdata[QL_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_ACTIVE_WORKERS: prdata = PDATA_W'(aw_reg);
            REG_QUEUE_LIMIT:    prdata = PDATA_W'(ql_reg);
            default:            prdata = '0;
        endcase
    end

    // out-of-range settings are clamped
    logic [NW_W-1:0]  eff_n;
    logic [CNT_W-1:0] eff_lim;

    always_comb
    begin
        if (aw_reg == '0)
            eff_n = NW_W'(1);
        else if (32'(aw_reg) > 32'(MAX_WORKERS))
            eff_n = NW_W'(MAX_WORKERS);
        else
            eff_n = NW_W'(aw_reg);

        if (ql_reg == '0)
            eff_lim = CNT_W'(1);
        else if (32'(ql_reg) > 32'(QUEUE_DEPTH))
            eff_lim = CNT_W'(QUEUE_DEPTH);
        else
            eff_lim = CNT_W'(ql_reg);
    end

    // ------------------------------------------------------------------
    // per-queue flags: pointer entry written since reset, queue non-empty
    // ------------------------------------------------------------------
    logic [MAX_WORKERS-1:0] ptr_vld_reg;
    logic [MAX_WORKERS-1:0] busy_reg;
    logic [TOTAL_W-1:0]     waiting_reg, waiting_next;

    // ------------------------------------------------------------------
    // accept stage: pick the target queue and start the pointer read
    // ------------------------------------------------------------------
    scan_res_t       scan;
    logic            acc;
    logic            in_range;
    logic            own_busy;
    logic            steal;
    logic            go;
    logic [WID_W-1:0] tgt;

    wstq_scan u_scan (
        .worker  (worker_id),
        .workers (eff_n),
        .busy    (busy_reg),
        .res     (scan)
    );

    assign in_ready = (state_reg == S_IDLE);
    assign acc      = in_valid && in_ready;
    assign in_range = NW_W'(worker_id) < eff_n;
    assign own_busy = busy_reg[worker_id];
    assign steal    = in_range && (kind == OP_POP) && !own_busy && scan.found;
    assign go       = in_range && ((kind == OP_PUSH) || own_busy || scan.found);
    assign tgt      = steal ? scan.queue : worker_id;

    // request held while it works
    logic                  op_kind_reg;
    logic [TASK_WIDTH-1:0] op_task_reg;
    logic [WID_W-1:0]      op_q_reg;
    logic                  op_go_reg;
    logic                  op_steal_reg;
    logic                  op_pvld_reg;

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            op_kind_reg  <= kind;
            op_task_reg  <= TASK_WIDTH'(task_handle);
            op_q_reg     <= tgt;
            op_go_reg    <= go;
            op_steal_reg <= steal;
            op_pvld_reg  <= ptr_vld_reg[tgt];
        end
    end

    // ------------------------------------------------------------------
    // pointer memory: {head, count} per queue
    // ------------------------------------------------------------------
    logic             ptr_we;
    logic [PTR_W-1:0] ptr_wdata;
    logic [PTR_W-1:0] ptr_rdata;
    logic [PTR_W-1:0] ptr_cur;
    logic [SLOT_W-1:0] head;
    logic [CNT_W-1:0]  cnt;
    logic [CNT_W-1:0]  cnt_new;
    logic [SLOT_W-1:0] head_inc;
    logic [SLOT_W:0]   slot_sum;
    logic [SLOT_W-1:0] slot;
    logic              push_ok;
    logic              pop_ok;

    wstq_ram #(
        .WIDTH (PTR_W),
        .DEPTH (MAX_WORKERS)
    ) u_ptr_ram (
        .clk   (clk),
        .we    (ptr_we),
        .waddr (op_q_reg),
        .wdata (ptr_wdata),
        .raddr (tgt),
        .rdata (ptr_rdata)
    );

    // never-written entries read as an empty queue at slot 0
    assign ptr_cur = op_pvld_reg ? ptr_rdata : '0;
    assign head    = ptr_cur[PTR_W-1:CNT_W];
    assign cnt     = ptr_cur[CNT_W-1:0];

    assign push_ok = (state_reg == S_RMW) && op_go_reg && (op_kind_reg == OP_PUSH)
                     && (cnt < eff_lim);
    assign pop_ok  = (state_reg == S_RMW) && op_go_reg && (op_kind_reg == OP_POP);

    assign head_inc = (head == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : head + SLOT_W'(1);
    assign slot_sum = (SLOT_W+1)'(head) + (SLOT_W+1)'(cnt[SLOT_W-1:0]);
    assign slot     = (slot_sum >= (SLOT_W+1)'(QUEUE_DEPTH))
                      ? SLOT_W'(slot_sum - (SLOT_W+1)'(QUEUE_DEPTH))
                      : SLOT_W'(slot_sum);
    assign cnt_new  = push_ok ? cnt + CNT_W'(1) : cnt - CNT_W'(1);

    assign ptr_we    = push_ok || pop_ok;
    assign ptr_wdata = push_ok ? {head, cnt_new} : {head_inc, cnt_new};

    always_comb
    begin
        waiting_next = waiting_reg;
        if (push_ok)
            waiting_next = waiting_reg + TOTAL_W'(1);
        else if (pop_ok)
            waiting_next = waiting_reg - TOTAL_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_vld_reg <= '0;
            busy_reg    <= '0;
            waiting_reg <= '0;
        end
        else
        begin
            waiting_reg <= waiting_next;
            if (ptr_we)
            begin
                ptr_vld_reg[op_q_reg] <= 1'b1;
                busy_reg[op_q_reg]    <= (cnt_new != '0);
            end
        end
    end

    // ------------------------------------------------------------------
    // task store: queue q slot s at q*QUEUE_DEPTH + s
    // ------------------------------------------------------------------
    logic [STORE_AW-1:0]   task_waddr;
    logic [STORE_AW-1:0]   task_raddr;
    logic [TASK_WIDTH-1:0] task_rdata;

    assign task_waddr = STORE_AW'(op_q_reg) * STORE_AW'(QUEUE_DEPTH) + STORE_AW'(slot);
    assign task_raddr = STORE_AW'(op_q_reg) * STORE_AW'(QUEUE_DEPTH) + STORE_AW'(head);

    wstq_ram #(
        .WIDTH (TASK_WIDTH),
        .DEPTH (STORE_DEPTH)
    ) u_task_ram (
        .clk   (clk),
        .we    (push_ok),
        .waddr (task_waddr),
        .wdata (op_task_reg),
        .raddr (task_raddr),
        .rdata (task_rdata)
    );

    // ------------------------------------------------------------------
    // result parking and output register
    // ------------------------------------------------------------------
    logic                pend_done_reg;
    logic [HANDLE_W-1:0] pend_task_reg;
    logic                pend_stolen_reg;
    logic [WID_W-1:0]    pend_src_reg;
    logic [TOTAL_W-1:0]  pend_wait_reg;

    logic                out_valid_reg;
    logic                out_done_reg;
    logic [HANDLE_W-1:0] out_task_reg;
    logic                out_stolen_reg;
    logic [WID_W-1:0]    out_src_reg;
    logic [TOTAL_W-1:0]  out_wait_reg;

    logic out_free;
    logic out_load;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        out_load   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (acc)
                    state_next = S_RMW;
            end
            S_RMW:
            begin
                if (pop_ok)
                    state_next = S_LOAD;
                else if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                    state_next = S_EMIT;
            end
            S_LOAD, S_EMIT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                    state_next = S_EMIT;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_RMW)
        begin
            pend_done_reg   <= push_ok || pop_ok;
            pend_task_reg   <= '0;
            pend_stolen_reg <= op_steal_reg && pop_ok;
            pend_src_reg    <= op_q_reg;
            pend_wait_reg   <= waiting_next;
        end
        else if (state_reg == S_LOAD)
        begin
            pend_task_reg <= HANDLE_W'(task_rdata);
        end

        if (out_load)
        begin
            if (state_reg == S_RMW)
            begin
                // push or failed pop: no task data
                out_done_reg   <= push_ok;
                out_task_reg   <= '0;
                out_stolen_reg <= 1'b0;
                out_src_reg    <= op_q_reg;
                out_wait_reg   <= waiting_next;
            end
            else
            begin
                out_done_reg   <= pend_done_reg;
                out_task_reg   <= (state_reg == S_LOAD) ? HANDLE_W'(task_rdata)
                                                        : pend_task_reg;
                out_stolen_reg <= pend_stolen_reg;
                out_src_reg    <= pend_src_reg;
                out_wait_reg   <= pend_wait_reg;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign done_res      = out_done_reg;
    assign task_out      = out_task_reg;
    assign stolen        = out_stolen_reg;
    assign source_queue  = out_src_reg;
    assign waiting_total = out_wait_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(waiting_reg) <= STORE_DEPTH)
        else $error("waiting count above store size");

    // busy flag and stored count must agree for the queue being popped
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RMW) && op_go_reg && (op_kind_reg == OP_POP) |-> cnt != '0)
        else $error("pop from a queue whose count is zero");

    a_accept_rmw: assert property (@(posedge clk) disable iff (!rst_n)
        acc |=> state_reg == S_RMW)
        else $error("accepted request did not enter update");

    a_load_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD) |-> $past(pop_ok))
        else $error("task read without a pop update");

endmodule

/* rtl/wstq_ram.sv */
// ----------------------------------------------------------------------------
// wstq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wstq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/wstq_scan.sv */
// ----------------------------------------------------------------------------
// wstq_scan
// Round-robin steal search: first busy queue after the requester, wrapping.
// ----------------------------------------------------------------------------
module wstq_scan
    import wstq_pkg::*;
(
    input  logic [WID_W-1:0]       worker,
    input  logic [NW_W-1:0]        workers,
    input  logic [MAX_WORKERS-1:0] busy,
    output scan_res_t              res
);

    always_comb
    begin
        logic [WID_W:0] sum;
        logic [WID_W:0] q;
        res.found = 1'b0;
        res.queue = worker;
        for (int i = 1; i < MAX_WORKERS; i++)
        begin
            sum = (WID_W+1)'(worker) + (WID_W+1)'(i);
            // worker < workers, so one subtract wraps
            q = (sum >= (WID_W+1)'(workers)) ? sum - (WID_W+1)'(workers) : sum;
            if (!res.found && (NW_W'(i) < workers) && busy[q[WID_W-1:0]])
            begin
                res.found = 1'b1;
                res.queue = q[WID_W-1:0];
            end
        end
    end

endmodule

/* tb/wstq_result_checker.sv */
// ----------------------------------------------------------------------------
// wstq_result_checker
// Tracks the per-worker task queues from the request and register traffic,
// predicts each result word and compares it with what the block returns.
// ----------------------------------------------------------------------------
module wstq_result_checker
    import wstq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic                kind,
    input  logic [WID_W-1:0]    worker_id,
    input  logic [HANDLE_W-1:0] task_handle,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic                done_res,
    input  logic [HANDLE_W-1:0] task_out,
    input  logic                stolen,
    input  logic [WID_W-1:0]    source_queue,
    input  logic [TOTAL_W-1:0]  waiting_total,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    input  logic [PDATA_W-1:0]  prdata,
    input  logic                pready,
    output int                  fail_count,
    output int                  open_words
);

    typedef struct {
        logic                done;
        logic [HANDLE_W-1:0] handle;
        logic                steal;
        logic [WID_W-1:0]    src;
        logic [TOTAL_W-1:0]  total;
    } result_t;

    result_t             queued_results [$];
    logic [HANDLE_W-1:0] slot_data [MAX_WORKERS][QUEUE_DEPTH];
    logic [SLOT_W-1:0]   oldest_slot [MAX_WORKERS];
    int                  fill [MAX_WORKERS];
    int                  held;
    logic [AW_W-1:0]     workers_reg;
    logic [QL_W-1:0]     limit_reg;

    // slot index wraps at the queue depth by its width
    function automatic logic [HANDLE_W-1:0] take_task(input int q);
        logic [HANDLE_W-1:0] t;
        t = slot_data[q][oldest_slot[q]];
        oldest_slot[q] = oldest_slot[q] + 1'b1;
        fill[q]--;
        held--;
        return t;
    endfunction

    function automatic result_t apply_request(input logic op, input logic [WID_W-1:0] w,
                                              input logic [HANDLE_W-1:0] h);
        result_t           r;
        int                n;
        int                lim;
        int                q;
        logic [SLOT_W-1:0] slot;
        n = (workers_reg == 0) ? 1 : (workers_reg > MAX_WORKERS) ? MAX_WORKERS
                                                                 : int'(workers_reg);
        lim = (limit_reg == 0) ? 1 : (limit_reg > QUEUE_DEPTH) ? QUEUE_DEPTH
                                                               : int'(limit_reg);
        r.done   = 1'b0;
        r.handle = '0;
        r.steal  = 1'b0;
        r.src    = w;
        if (w < n)
        begin
            if (op == OP_PUSH)
            begin
                if (fill[w] < lim)
                begin
                    slot = SLOT_W'(oldest_slot[w] + fill[w]);
                    slot_data[w][slot] = h;
                    fill[w]++;
                    held++;
                    r.done = 1'b1;
                end
            end
            else if (fill[w] > 0)
            begin
                r.handle = take_task(w);
                r.done   = 1'b1;
            end
            else
            begin
                // steal scan: next worker up, wrapping at the active count
                for (int i = 1; i < n; i++)
                begin
                    q = (w + i) % n;
                    if (!r.done && fill[q] > 0)
                    begin
                        r.handle = take_task(q);
                        r.done   = 1'b1;
                        r.steal  = 1'b1;
                        r.src    = WID_W'(q);
                    end
                end
            end
        end
        r.total = TOTAL_W'(held);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t            want;
        logic [PDATA_W-1:0] rd_want;
        if (!rst_n)
        begin
            for (int q = 0; q < MAX_WORKERS; q++)
            begin
                oldest_slot[q] = '0;
                fill[q]        = 0;
            end
            held        = 0;
            workers_reg = AW_W'(MAX_WORKERS);
            limit_reg   = QL_W'(QUEUE_DEPTH);
            queued_results.delete();
            fail_count  = 0;
        end
        else
        begin
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    if (paddr[PADDR_W-1:2] == REG_ACTIVE_WORKERS)
                        workers_reg = pwdata[AW_W-1:0];
                    else
                        limit_reg = pwdata[QL_W-1:0];
                end
                else
                begin
                    rd_want = (paddr[PADDR_W-1:2] == REG_ACTIVE_WORKERS)
                              ? PDATA_W'(workers_reg) : PDATA_W'(limit_reg);
                    if (prdata !== rd_want)
                    begin
                        fail_count++;
                        $display("%0t: register read at %0d, expected %h, got %h",
                                 $time, paddr, rd_want, prdata);
                    end
                end
            end
            if (in_valid && in_ready)
                queued_results.push_back(apply_request(kind, worker_id, task_handle));
            if (out_valid && out_ready)
            begin
                if (queued_results.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: expected no result word, got done %0b task %h ",
                             $time, done_res, task_out,
                             "stolen %0b src %0d total %0d",
                             stolen, source_queue, waiting_total);
                end
                else
                begin
                    want = queued_results.pop_front();
                    if (done_res !== want.done || task_out !== want.handle ||
                        stolen !== want.steal || source_queue !== want.src ||
                        waiting_total !== want.total)
                    begin
                        fail_count++;
                        $display("%0t: expected done %0b task %h stolen %0b ",
                                 $time, want.done, want.handle, want.steal,
                                 "src %0d total %0d, ", want.src, want.total,
                                 "got done %0b task %h stolen %0b ",
                                 done_res, task_out, stolen,
                                 "src %0d total %0d", source_queue, waiting_total);
                    end
                end
            end
        end
        open_words = queued_results.size();
    end

endmodule

/* tb/tb_work_stealing_task_queues.sv */
// ----------------------------------------------------------------------------
// tb_work_stealing_task_queues
// Drives push and pop words and register writes into the task queues, with
// random idling on both channels; the checker beside the block predicts and
// compares every result word, and this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_work_stealing_task_queues;
    import wstq_pkg::*;

    // idle cycles in a row before the run is declared hung
    localparam int STALL_LIMIT = 4000;
    // random words per register setting
    localparam int SEG_WORDS   = 155;
    localparam int SEG_COUNT   = 12;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic                kind = OP_PUSH;
    logic [WID_W-1:0]    worker_id = '0;
    logic [HANDLE_W-1:0] task_handle = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic                done_res;
    logic [HANDLE_W-1:0] task_out;
    logic                stolen;
    logic [WID_W-1:0]    source_queue;
    logic [TOTAL_W-1:0]  waiting_total;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [PDATA_W-1:0]  pwdata = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    int fail_count;
    int open_words;
    int send_idle_pct = 33;
    int recv_idle_pct = 71;
    int live_workers  = MAX_WORKERS;
    int stall_cycles  = 0;

    // Register settings for the random part. Worker counts 0, 17 and 31 and
    // limits 0, 100 and 127 are out of range and get clamped by the block.
    // The single-worker, limit-64 setting pushes hard enough to fill a queue.
    int seg_workers  [SEG_COUNT] = '{16,  1, 16,  5,  31, 0,  1, 16,  8,  17, 3, 16};
    int seg_limit    [SEG_COUNT] = '{64,  1,  1,  7, 127, 0, 64,  3, 16, 100, 2, 64};
    int seg_push_pct [SEG_COUNT] = '{50, 50, 60, 70,  40, 50, 85, 55, 75,  30, 50, 50};

    work_stealing_task_queues uut (.*);

    wstq_result_checker chk (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result-side backpressure, redrawn every cycle
    always @(negedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // hang detector: any handshake or register access resets the count
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("tb_work_stealing_task_queues: errors");
            $finish;
        end
    end

    // Offer one request word. Called at a falling edge; returns at the
    // falling edge after the word was taken, with valid still high so the
    // next call can follow back to back.
    task automatic issue_word(input logic op, input logic [WID_W-1:0] w,
                              input logic [HANDLE_W-1:0] h);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(negedge clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_valid    <= 1'b1;
        kind        <= op;
        worker_id   <= w;
        task_handle <= h;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    // setup cycle, then access cycle, then the bus is left idle before returning
    task automatic apb_access(input logic wr, input reg_idx_t idx,
                              input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // stop offering words and wait until every result word has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        while (open_words != 0)
            @(negedge clk);
    endtask

    // registers change only with the block idle; read back both after writing
    task automatic load_config(input logic [AW_W-1:0] nw, input logic [QL_W-1:0] lim);
        drain_results();
        apb_access(1'b1, REG_ACTIVE_WORKERS, PDATA_W'(nw));
        apb_access(1'b1, REG_QUEUE_LIMIT, PDATA_W'(lim));
        apb_access(1'b0, REG_ACTIVE_WORKERS, '0);
        apb_access(1'b0, REG_QUEUE_LIMIT, '0);
        live_workers = (nw == 0) ? 1 : (nw > MAX_WORKERS) ? MAX_WORKERS : int'(nw);
    endtask

    initial
    begin
        int                  hot;
        int                  pick;
        logic                op;
        logic [WID_W-1:0]    w;
        logic [HANDLE_W-1:0] h;

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // --- directed part, reset settings: 16 workers, 64 deep ---
        issue_word(OP_POP, 0, $urandom);            // every queue empty: pop fails
        issue_word(OP_PUSH, 0, 32'h0000_0000);
        issue_word(OP_PUSH, 15, 32'hFFFF_FFFF);
        issue_word(OP_PUSH, 3, $urandom);
        issue_word(OP_POP, 0, $urandom);            // own queue
        issue_word(OP_POP, 0, $urandom);            // steal from 3
        issue_word(OP_POP, 0, $urandom);            // steal from 15
        issue_word(OP_PUSH, 2, 32'h5A5A_A5A5);
        issue_word(OP_POP, 15, $urandom);           // scan wraps past 15 to 2

        // four workers, two slots each
        load_config(4, 2);
        repeat (3) issue_word(OP_PUSH, 1, $urandom); // third one finds the queue full
        issue_word(OP_PUSH, 9, $urandom);           // worker not active: refused
        issue_word(OP_POP, 3, $urandom);            // wraps to 0, steals from 1
        issue_word(OP_PUSH, 3, $urandom);

        // drop to two workers: the task on 3 is stranded but still counted
        load_config(2, 2);
        issue_word(OP_POP, 0, $urandom);
        issue_word(OP_POP, 0, $urandom);

        // zero in both registers reads as one worker, one slot
        load_config(0, 0);
        issue_word(OP_PUSH, 0, $urandom);
        issue_word(OP_PUSH, 0, $urandom);
        issue_word(OP_POP, 1, $urandom);
        issue_word(OP_POP, 0, $urandom);

        // oversized values clamp to 16 and 64; queue 3 becomes reachable
        load_config(31, 127);
        issue_word(OP_POP, 6, $urandom);
        issue_word(OP_PUSH, 7, $urandom);
        issue_word(OP_PUSH, 7, $urandom);

        // limit lowered under the fill level: held tasks stay poppable
        load_config(16, 1);
        issue_word(OP_PUSH, 7, $urandom);
        issue_word(OP_POP, 7, $urandom);
        issue_word(OP_PUSH, 7, $urandom);
        issue_word(OP_POP, 7, $urandom);
        issue_word(OP_PUSH, 7, $urandom);

        // --- random part: one register setting per segment ---
        // idling: sender light / receiver heavy, then swapped, then none
        for (int s = 0; s < SEG_COUNT; s++)
        begin
            load_config(AW_W'(seg_workers[s]), QL_W'(seg_limit[s]));
            send_idle_pct = (s < 4) ? 33 : (s < 8) ? 71 : 0;
            recv_idle_pct = (s < 4) ? 71 : (s < 8) ? 33 : 0;
            // one busy worker per segment so its queue fills and empties
            hot = $urandom_range(0, live_workers - 1);
            for (int k = 0; k < SEG_WORDS; k++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 8)
                    w = WID_W'($urandom_range(0, MAX_WORKERS - 1));   // may be inactive
                else if (pick < 45)
                    w = WID_W'(hot);
                else
                    w = WID_W'($urandom_range(0, live_workers - 1));
                op = ($urandom_range(0, 99) < seg_push_pct[s]) ? OP_PUSH : OP_POP;
                case ($urandom_range(0, 15))
                    0:       h = '0;
                    1:       h = '1;
                    default: h = $urandom;
                endcase
                issue_word(op, w, h);
            end
        end

        drain_results();
        // idle on to catch any stray result word
        repeat (8) @(negedge clk);
        if (fail_count == 0)
            $display("tb_work_stealing_task_queues: clean");
        else
            $display("tb_work_stealing_task_queues: errors");
        $finish;
    end

endmodule

/* sim.f */
rtl/wstq_pkg.sv
rtl/wstq_ram.sv
rtl/wstq_scan.sv
rtl/work_stealing_task_queues.sv
tb/wstq_result_checker.sv
tb/tb_work_stealing_task_queues.sv
